// ===== rtl/core/equatorial_to_galactic_convert_macros.svh =====
// Assertion helpers shared by the conversion core.
`ifndef EQUATORIAL_TO_GALACTIC_CONVERT_MACROS_SVH
`define EQUATORIAL_TO_GALACTIC_CONVERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define EGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/egc_pkg.sv =====
`timescale 1ns / 1ps
package egc_pkg;

  localparam int unsigned IO_BITS = 24;

  // CORDIC gain compensation and the rounding half for Q1.30 products.
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032875;
  localparam logic signed [63:0] Q30_HALF        = 64'sd536870912;

  // Arctangent of 2^-i, 2^32 units per turn.
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Rotation matrix entries, scaled from 1e-12 units to Q1.30 with rounding.
  localparam longint GM0 = -((64'sd54875539726  * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM1 = -((64'sd873437108010 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM2 = -((64'sd483834985808 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM3 =  ((64'sd494109453312 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM4 = -((64'sd444829589425 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM5 =  ((64'sd746982251810 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM6 = -((64'sd867666135858 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM7 = -((64'sd198076386122 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
  localparam longint GM8 =  ((64'sd455983795705 * 64'sd262144 + 64'sd122070312) / 64'sd244140625);

  localparam logic signed [31:0] GAL_M [9] = '{
    32'(GM0), 32'(GM1), 32'(GM2), 32'(GM3), 32'(GM4), 32'(GM5), 32'(GM6), 32'(GM7), 32'(GM8)
  };

  // Arctangent step for stage i, rounded half up to ab bits per turn.
  function automatic logic [32:0] atan_step(input int i, input int ab);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[i[4:0]]};
    if (ab < 32) begin
      t = (t + (33'd1 << (31 - ab))) >> (32 - ab);
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/egc_rot_cell.sv =====
`timescale 1ns / 1ps
module egc_rot_cell import egc_pkg::*; #(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = 24,
  parameter int XW         = 34,
  parameter int SIDE_W     = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [XW-1:0]         x_i,
  input  logic signed [XW-1:0]         y_i,
  input  logic signed [ANGLE_BITS+1:0] z_i,
  input  logic        [SIDE_W-1:0]     side_i,
  output logic                        valid_o,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic signed [ANGLE_BITS+1:0] z_o,
  output logic        [SIDE_W-1:0]     side_o
);

  localparam logic signed [ANGLE_BITS+1:0] STEP = (ANGLE_BITS+2)'(atan_step(STAGE, ANGLE_BITS));

  logic signed [XW-1:0]         x_d, y_d, dx, dy;
  logic signed [ANGLE_BITS+1:0] z_d;

  always_comb begin
    dx = x_i >>> STAGE;
    dy = y_i >>> STAGE;
    if (z_i >= 0) begin
      x_d = x_i - dy;
      y_d = y_i + dx;
      z_d = z_i - STEP;
    end else begin
      x_d = x_i + dy;
      y_d = y_i - dx;
      z_d = z_i + STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    z_o    <= z_d;
    side_o <= side_i;
  end

endmodule

// ===== rtl/core/egc_vec_cell.sv =====
`timescale 1ns / 1ps
module egc_vec_cell import egc_pkg::*; #(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = 24,
  parameter int XW         = 36,
  parameter int SIDE_W     = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [XW-1:0]         x_i,
  input  logic signed [XW-1:0]         y_i,
  input  logic signed [ANGLE_BITS+1:0] z_i,
  input  logic        [SIDE_W-1:0]     side_i,
  output logic                        valid_o,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic signed [ANGLE_BITS+1:0] z_o,
  output logic        [SIDE_W-1:0]     side_o
);

  localparam logic signed [ANGLE_BITS+1:0] STEP = (ANGLE_BITS+2)'(atan_step(STAGE, ANGLE_BITS));

  logic signed [XW-1:0]         x_d, y_d, dx, dy;
  logic signed [ANGLE_BITS+1:0] z_d;

  // Drive y toward zero; the accumulated angle is atan2(y, x).
  always_comb begin
    dx = x_i >>> STAGE;
    dy = y_i >>> STAGE;
    if (y_i > 0) begin
      x_d = x_i + dy;
      y_d = y_i - dx;
      z_d = z_i + STEP;
    end else begin
      x_d = x_i - dy;
      y_d = y_i + dx;
      z_d = z_i - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    z_o    <= z_d;
    side_o <= side_i;
  end

endmodule

// ===== rtl/core/egc_matrix.sv =====
`timescale 1ns / 1ps
module egc_matrix import egc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] cr_i,
  input  logic signed [31:0] sr_i,
  input  logic signed [31:0] cd_i,
  input  logic signed [31:0] sd_i,
  output logic               valid_o,
  output logic signed [35:0] r_o [3]
);

  logic [3:0]         vld_q;
  logic signed [63:0] p0_q, p1_q;
  logic signed [31:0] sd_q;
  logic signed [31:0] v_q [3];
  logic signed [63:0] m_q [9];
  logic signed [65:0] acc [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = 66'(m_q[3*k]) + 66'(m_q[3*k+1]) + 66'(m_q[3*k+2]) + 66'(Q30_HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= cr_i * cd_i;
    p1_q <= sr_i * cd_i;
    sd_q <= sd_i;
    v_q[0] <= 32'((p0_q + Q30_HALF) >>> 30);
    v_q[1] <= 32'((p1_q + Q30_HALF) >>> 30);
    v_q[2] <= sd_q;
    for (int j = 0; j < 9; j++) begin
      m_q[j] <= GAL_M[j] * v_q[j % 3];
    end
    for (int k = 0; k < 3; k++) begin
      r_o[k] <= 36'(acc[k] >>> 30);
    end
  end

  assign valid_o = vld_q[3];

endmodule

// ===== rtl/core/equatorial_to_galactic_convert.sv =====
`timescale 1ns / 1ps
// Converts J2000 right ascension and declination into galactic longitude and
// latitude. A request is taken in every cycle (busy_o stays low) and its result
// appears on done_o in request order. The pipeline runs through three chains of
// CORDIC cells (sine/cosine, longitude, latitude), one cell per stage, plus the
// four-stage matrix rotation and the gain-correction multiplier. The result is
// shown for one cycle only; the receiver has to take it when done_o is high.
`include "equatorial_to_galactic_convert_macros.svh"
module equatorial_to_galactic_convert import egc_pkg::*; #(
  parameter int CORDIC_STAGES = 24,
  parameter int ANGLE_BITS    = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic        [23:0] right_ascension_i,
  input  logic signed [23:0] declination_i,
  output logic               done_o,
  output logic        [23:0] galactic_longitude_o,
  output logic signed [23:0] galactic_latitude_o
);

  localparam int S  = CORDIC_STAGES;
  localparam int A  = ANGLE_BITS;
  localparam int ZW = A + 2;
  localparam int RW = 34;
  localparam int VW = 36;
  localparam int SHL_I = (A >= IO_BITS) ? A - IO_BITS : 0;
  localparam int SHR_I = (A < IO_BITS) ? IO_BITS - A : 0;
  localparam int SHL_O = (A < IO_BITS) ? IO_BITS - A : 0;
  localparam int SHR_O = (A > IO_BITS) ? A - IO_BITS : 0;
  localparam logic signed [39:0] RND_I = (SHR_I > 0) ? (40'sd1 <<< (SHR_I - 1)) : 40'sd0;
  localparam logic signed [39:0] RND_O = (SHR_O > 0) ? (40'sd1 <<< (SHR_O - 1)) : 40'sd0;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (A - 2);
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (A - 1);
  localparam logic signed [RW-1:0] GAIN_X  = RW'(CORDIC_GAIN_Q30);

  assign busy_o = 1'b0;

  // Input angle scaling and quadrant folding.
  logic signed [39:0]   ra_w, dec_w;
  logic signed [A-1:0]  ra_a, dec_a;
  logic signed [ZW-1:0] ra_z, dec_z, ra_zd, dec_zd;
  logic                 ra_nd, dec_nd;

  always_comb begin
    ra_w  = {16'd0, right_ascension_i};
    dec_w = 40'(declination_i);
    if (A >= IO_BITS) begin
      ra_w  = ra_w <<< SHL_I;
      dec_w = dec_w <<< SHL_I;
    end else begin
      ra_w  = (ra_w + RND_I) >>> SHR_I;
      dec_w = (dec_w + RND_I) >>> SHR_I;
    end
    ra_a  = ra_w[A-1:0];
    dec_a = dec_w[A-1:0];
    ra_z  = ZW'(ra_a);
    dec_z = ZW'(dec_a);
    ra_nd = 1'b1;
    ra_zd = ra_z;
    if (ra_z > QUARTER) begin
      ra_zd = ra_z - HALF;
    end else if (ra_z < -QUARTER) begin
      ra_zd = ra_z + HALF;
    end else begin
      ra_nd = 1'b0;
    end
    dec_nd = 1'b1;
    dec_zd = dec_z;
    if (dec_z > QUARTER) begin
      dec_zd = dec_z - HALF;
    end else if (dec_z < -QUARTER) begin
      dec_zd = dec_z + HALF;
    end else begin
      dec_nd = 1'b0;
    end
  end

  logic                 rv [S+1];
  logic                 dv [S+1];
  logic signed [RW-1:0] rx [S+1], ry [S+1], dx [S+1], dy [S+1];
  logic signed [ZW-1:0] rz [S+1], dz [S+1];
  logic                 rn [S+1], dn [S+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv[0] <= 1'b0;
      dv[0] <= 1'b0;
    end else begin
      rv[0] <= start_i;
      dv[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx[0] <= GAIN_X;
    ry[0] <= '0;
    rz[0] <= ra_zd;
    rn[0] <= ra_nd;
    dx[0] <= GAIN_X;
    dy[0] <= '0;
    dz[0] <= dec_zd;
    dn[0] <= dec_nd;
  end

  for (genvar i = 0; i < S; i++) begin : g_rot
    egc_rot_cell #(.STAGE(i), .ANGLE_BITS(A), .XW(RW), .SIDE_W(1)) u_ra (
      .clk_i, .rst_ni,
      .valid_i(rv[i]), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]), .side_i(rn[i]),
      .valid_o(rv[i+1]), .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1]), .side_o(rn[i+1])
    );
    egc_rot_cell #(.STAGE(i), .ANGLE_BITS(A), .XW(RW), .SIDE_W(1)) u_dec (
      .clk_i, .rst_ni,
      .valid_i(dv[i]), .x_i(dx[i]), .y_i(dy[i]), .z_i(dz[i]), .side_i(dn[i]),
      .valid_o(dv[i+1]), .x_o(dx[i+1]), .y_o(dy[i+1]), .z_o(dz[i+1]), .side_o(dn[i+1])
    );
  end

  logic signed [31:0] cr, sr, cd, sd;
  logic signed [RW-1:0] cr_w, sr_w, cd_w, sd_w;

  always_comb begin
    cr_w = rn[S] ? -rx[S] : rx[S];
    sr_w = rn[S] ? -ry[S] : ry[S];
    cd_w = dn[S] ? -dx[S] : dx[S];
    sd_w = dn[S] ? -dy[S] : dy[S];
    cr = cr_w[31:0];
    sr = sr_w[31:0];
    cd = cd_w[31:0];
    sd = sd_w[31:0];
  end

  logic               mv;
  logic signed [35:0] r [3];

  egc_matrix u_matrix (
    .clk_i, .rst_ni,
    .valid_i(rv[S]), .cr_i(cr), .sr_i(sr), .cd_i(cd), .sd_i(sd),
    .valid_o(mv), .r_o(r)
  );

  // Longitude chain: atan2(r1, r0), carrying r2 and the pole flag alongside.
  localparam int LSW = VW + 1;
  logic                 lv [S+1];
  logic signed [VW-1:0] lx [S+1], ly [S+1];
  logic signed [ZW-1:0] lz [S+1];
  logic [LSW-1:0]       ls [S+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv[0] <= 1'b0;
    end else begin
      lv[0] <= mv;
    end
  end

  always_ff @(posedge clk_i) begin
    ls[0] <= {(r[0] == '0) && (r[1] == '0), r[2]};
    if (r[0] < 0) begin
      lx[0] <= -r[0];
      ly[0] <= -r[1];
      lz[0] <= HALF;
    end else begin
      lx[0] <= r[0];
      ly[0] <= r[1];
      lz[0] <= '0;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_lon
    egc_vec_cell #(.STAGE(i), .ANGLE_BITS(A), .XW(VW), .SIDE_W(LSW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(lv[i]), .x_i(lx[i]), .y_i(ly[i]), .z_i(lz[i]), .side_i(ls[i]),
      .valid_o(lv[i+1]), .x_o(lx[i+1]), .y_o(ly[i+1]), .z_o(lz[i+1]), .side_o(ls[i+1])
    );
  end

  // Gain correction of the xy magnitude.
  logic                 gv_q;
  logic signed [63:0]   gp_q;
  logic [A-1:0]         glon_q;
  logic                 gzero_q;
  logic signed [VW-1:0] gr2_q;
  logic signed [VW-1:0] rxy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
    end else begin
      gv_q <= lv[S];
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q    <= lx[S][31:0] * CORDIC_GAIN_Q30;
    glon_q  <= lz[S][A-1:0];
    gzero_q <= ls[S][LSW-1];
    gr2_q   <= ls[S][VW-1:0];
  end

  assign rxy = VW'((gp_q + Q30_HALF) >>> 30);

  // Latitude chain: atan2(r2, rxy), carrying the longitude and zero flag.
  localparam int TSW = A + 1;
  logic                 tv [S+1];
  logic signed [VW-1:0] tx [S+1], ty [S+1];
  logic signed [ZW-1:0] tz [S+1];
  logic [TSW-1:0]       ts [S+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv[0] <= 1'b0;
    end else begin
      tv[0] <= gv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tx[0] <= rxy;
    ty[0] <= gr2_q;
    tz[0] <= '0;
    ts[0] <= {(rxy == '0) && (gr2_q == '0), gzero_q ? '0 : glon_q};
  end

  for (genvar i = 0; i < S; i++) begin : g_lat
    egc_vec_cell #(.STAGE(i), .ANGLE_BITS(A), .XW(VW), .SIDE_W(TSW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(tv[i]), .x_i(tx[i]), .y_i(ty[i]), .z_i(tz[i]), .side_i(ts[i]),
      .valid_o(tv[i+1]), .x_o(tx[i+1]), .y_o(ty[i+1]), .z_o(tz[i+1]), .side_o(ts[i+1])
    );
  end

  // Output scaling back to 24-bit angle units.
  logic signed [39:0] lon_w, lat_w;

  always_comb begin
    lon_w = {{(40-A){1'b0}}, ts[S][A-1:0]};
    lat_w = ts[S][A] ? 40'sd0 : 40'(tz[S]);
    if (A <= IO_BITS) begin
      lon_w = lon_w <<< SHL_O;
      lat_w = lat_w <<< SHL_O;
    end else begin
      lon_w = (lon_w + RND_O) >>> SHR_O;
      lat_w = (lat_w + RND_O) >>> SHR_O;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= tv[S];
    end
  end

  always_ff @(posedge clk_i) begin
    galactic_longitude_o <= lon_w[23:0];
    galactic_latitude_o  <= lat_w[23:0];
  end

  `EGC_ASSERT_NXT(a_start_enters, start_i, rv[0] && dv[0], "request did not enter the pipeline")
  `EGC_ASSERT_IMP(a_chains_aligned, 1'b1, rv[S] == dv[S], "sine/cosine chains out of step")
  `EGC_ASSERT_NXT(a_lon_to_gain, lv[S], gv_q, "longitude result lost before gain stage")
  `EGC_ASSERT_NXT(a_lat_to_done, tv[S], done_o, "latitude result lost before output")

endmodule
